[hw/rtl/itoa_pkg.sv]
// ----------------------------------------------------------------------------
// itoa_pkg: shared definitions for the integer to ASCII converter
// Holds widths, selector codes, ASCII constants and the BCD digit helpers.
// ----------------------------------------------------------------------------
package itoa_pkg;

    // Width of the unsigned wide kind; 32-bit kinds use the low 32 bits.
    localparam int VALUE_WIDTH = 64;
    // Longest text run: twenty decimal digits for a 64-bit value.
    localparam int MAX_CHARS   = 20;
    localparam int DIGITS_W    = 4 * MAX_CHARS;
    localparam int CNT_W       = $clog2(MAX_CHARS + 1);
    localparam int BITS_W      = $clog2(VALUE_WIDTH + 1);

    // Kind selector codes.
    localparam logic [1:0] FUNC_S32 = 2'd0;
    localparam logic [1:0] FUNC_U32 = 2'd1;
    localparam logic [1:0] FUNC_U64 = 2'd2;

    // Radix selector codes.
    localparam logic [1:0] RADIX_DEC  = 2'd0;
    localparam logic [1:0] RADIX_LHEX = 2'd1;
    localparam logic [1:0] RADIX_UHEX = 2'd2;

    // ASCII characters used by the converter.
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_LOW_A = 8'h61;
    localparam logic [7:0] ASCII_UP_A  = 8'h41;
    localparam logic [7:0] ASCII_MINUS = 8'h2d;

    // Map one digit to its ASCII character.
    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] ch;
        if (d < 4'd10) begin
            ch = ASCII_ZERO + {4'd0, d};
        end else if (upper) begin
            ch = ASCII_UP_A + {4'd0, d - 4'd10};
        end else begin
            ch = ASCII_LOW_A + {4'd0, d - 4'd10};
        end
        return ch;
    endfunction

    // Add three to every BCD digit that is five or more (double dabble step).
    function automatic logic [DIGITS_W-1:0] bcd_adjust(input logic [DIGITS_W-1:0] d);
        logic [DIGITS_W-1:0] res;
        res = d;
        for (int k = 0; k < MAX_CHARS; k++) begin
            if (d[4*k +: 4] >= 4'd5) begin
                res[4*k +: 4] = d[4*k +: 4] + 4'd3;
            end
        end
        return res;
    endfunction

    // True when every digit of the word is a legal BCD digit.
    function automatic logic bcd_valid(input logic [DIGITS_W-1:0] d);
        logic ok;
        ok = 1'b1;
        for (int k = 0; k < MAX_CHARS; k++) begin
            if (d[4*k +: 4] > 4'd9) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

[hw/rtl/integer_to_ascii_radix.sv]
// ----------------------------------------------------------------------------
// integer_to_ascii_radix: integer to ASCII text converter
// Converts a signed or unsigned integer into decimal or hex characters,
// most significant first, and flags the last character of each run.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake                 | Payload
//  --------+---------------------------+-----------------------------------
//  in      | i_in_valid / o_in_ready   | i_func, i_radix_sel, i_raw_value
//  out     | o_out_valid / i_out_ready | o_char_out, o_last_char
//
// A decimal request runs VALUE_WIDTH (64) shift-and-add-3 steps on one shared
// BCD adjust unit; a hex request loads its nibbles directly. Leading zeros are
// dropped at one per cycle (up to 19), then one character goes out per cycle
// while the output side takes them. A new request is taken only in idle, once
// the last character of the run is loaded for output. Reset is synchronous,
// active low, to idle.
module integer_to_ascii_radix (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic [1:0]  i_radix_sel,
    input  logic [63:0] i_raw_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_char_out,
    output logic        o_last_char
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CONV = 5'b00010,
        S_TRIM = 5'b00100,
        S_SIGN = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    t_state                               r_state, n_state;
    logic [itoa_pkg::DIGITS_W-1:0]        r_digs, n_digs;
    logic [itoa_pkg::VALUE_WIDTH-1:0]     r_val, n_val;
    logic [itoa_pkg::BITS_W-1:0]          r_bits, n_bits;
    logic [itoa_pkg::CNT_W-1:0]           r_cnt, n_cnt;
    logic                                 r_hex, n_hex;
    logic                                 r_upper, n_upper;
    logic                                 r_neg, n_neg;
    logic                                 r_out_valid, n_out_valid;
    logic [7:0]                           r_char, n_char;
    logic                                 r_last, n_last;

    logic [31:0]                          w_low;
    logic [31:0]                          w_low_neg;
    logic                                 w_neg;
    logic [itoa_pkg::VALUE_WIDTH-1:0]     w_mag;
    logic                                 w_is_hex;
    logic [itoa_pkg::DIGITS_W-1:0]        w_adj;
    logic                                 w_out_free;

    // Magnitude of the incoming request according to its kind.
    assign w_low     = i_raw_value[31:0];
    assign w_low_neg = ~w_low + 32'd1;
    assign w_neg     = (i_func == itoa_pkg::FUNC_S32) && w_low[31];
    assign w_is_hex  = (i_radix_sel == itoa_pkg::RADIX_LHEX) ||
                       (i_radix_sel == itoa_pkg::RADIX_UHEX);

    always_comb begin
        case (i_func)
            itoa_pkg::FUNC_S32: begin
                w_mag = w_neg ? itoa_pkg::VALUE_WIDTH'(w_low_neg)
                              : itoa_pkg::VALUE_WIDTH'(w_low);
            end
            itoa_pkg::FUNC_U32: begin
                w_mag = itoa_pkg::VALUE_WIDTH'(w_low);
            end
            default: begin
                w_mag = i_raw_value[itoa_pkg::VALUE_WIDTH-1:0];
            end
        endcase
    end

    // Shared BCD adjust unit and output register availability.
    assign w_adj      = itoa_pkg::bcd_adjust(r_digs);
    assign w_out_free = !r_out_valid || i_out_ready;

    // Sequencer: conversion, leading zero trim, sign and character emission.
    always_comb begin
        n_state     = r_state;
        n_digs      = r_digs;
        n_val       = r_val;
        n_bits      = r_bits;
        n_cnt       = r_cnt;
        n_hex       = r_hex;
        n_upper     = r_upper;
        n_neg       = r_neg;
        n_out_valid = r_out_valid && !i_out_ready;
        n_char      = r_char;
        n_last      = r_last;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_hex   = w_is_hex;
                    n_upper = (i_radix_sel == itoa_pkg::RADIX_UHEX);
                    n_neg   = w_neg;
                    n_cnt   = itoa_pkg::CNT_W'(itoa_pkg::MAX_CHARS);
                    n_val   = w_mag;
                    n_bits  = itoa_pkg::BITS_W'(itoa_pkg::VALUE_WIDTH);
                    if (w_is_hex) begin
                        n_digs  = itoa_pkg::DIGITS_W'(w_mag);
                        n_state = S_TRIM;
                    end else begin
                        n_digs  = '0;
                        n_state = S_CONV;
                    end
                end
            end
            S_CONV: begin
                n_digs = {w_adj[itoa_pkg::DIGITS_W-2:0], r_val[itoa_pkg::VALUE_WIDTH-1]};
                n_val  = {r_val[itoa_pkg::VALUE_WIDTH-2:0], 1'b0};
                n_bits = r_bits - itoa_pkg::BITS_W'(1);
                if (r_bits == itoa_pkg::BITS_W'(1)) begin
                    n_state = S_TRIM;
                end
            end
            S_TRIM: begin
                if ((r_digs[itoa_pkg::DIGITS_W-1 -: 4] == 4'd0) &&
                    (r_cnt != itoa_pkg::CNT_W'(1))) begin
                    n_digs = {r_digs[itoa_pkg::DIGITS_W-5:0], 4'd0};
                    n_cnt  = r_cnt - itoa_pkg::CNT_W'(1);
                end else begin
                    n_state = r_neg ? S_SIGN : S_EMIT;
                end
            end
            S_SIGN: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = itoa_pkg::ASCII_MINUS;
                    n_last      = 1'b0;
                    n_state     = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = itoa_pkg::digit_char(r_digs[itoa_pkg::DIGITS_W-1 -: 4],
                                                       r_upper);
                    n_last      = (r_cnt == itoa_pkg::CNT_W'(1));
                    n_digs      = {r_digs[itoa_pkg::DIGITS_W-5:0], 4'd0};
                    n_cnt       = r_cnt - itoa_pkg::CNT_W'(1);
                    if (r_cnt == itoa_pkg::CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_digs  <= n_digs;
        r_val   <= n_val;
        r_bits  <= n_bits;
        r_cnt   <= n_cnt;
        r_hex   <= n_hex;
        r_upper <= n_upper;
        r_neg   <= n_neg;
        r_char  <= n_char;
        r_last  <= n_last;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_char_out  = r_char;
    assign o_last_char = r_last;

    // Checks on the sequencer.
    a_conv_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CONV) |-> (r_bits != '0))
        else $error("conversion running with no bits left");

    a_emit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT || r_state == S_SIGN) |-> (r_cnt != '0))
        else $error("emission running with no digits left");

    a_bcd_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TRIM && !r_hex) |-> itoa_pkg::bcd_valid(r_digs))
        else $error("illegal BCD digit after conversion");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_CONV || r_state == S_TRIM))
        else $error("accepted request did not start conversion");

    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && w_out_free && r_cnt == itoa_pkg::CNT_W'(1)) |=>
        (r_state == S_IDLE && o_out_valid && o_last_char))
        else $error("final character did not end the run");

endmodule
